// ===== design/bred_pkg.sv =====
// shared types, constants and partial-product helpers for the barrett reduction core
// no dependencies; imported by every module of the core
`default_nettype none

package bred_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int MOD_W = 63;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODULUS    = 2'd0,
        CFG_RATIO_LOW  = 2'd1,
        CFG_RATIO_HIGH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [MOD_W-1:0]  modulus;
        logic [WORD_W-1:0] ratio_low;
        logic [WORD_W-1:0] ratio_high;
    } cfg_t;

    // four 32x32 partial products of one 64x64 multiply
    typedef struct packed {
        logic [WORD_W-1:0] p00;
        logic [WORD_W-1:0] p01;
        logic [WORD_W-1:0] p10;
        logic [WORD_W-1:0] p11;
    } pp_t;

    // handoff from the estimate front end to the correction back end
    typedef struct packed {
        logic [WORD_W-1:0] est;
        logic [WORD_W-1:0] x0;
    } q_entry_t;

    // full 64-bit product of two 32-bit halves
    function automatic logic [WORD_W-1:0] mul_half(
        input logic [HALF_W-1:0] a,
        input logic [HALF_W-1:0] b
    );
        return {{HALF_W{1'b0}}, a} * {{HALF_W{1'b0}}, b};
    endfunction

    // full 128-bit product from registered partial products
    function automatic logic [2*WORD_W-1:0] pp_full(input pp_t pp);
        logic [2*WORD_W-1:0] s;
        s = {pp.p11, pp.p00}
            + {{HALF_W{1'b0}}, pp.p01, {HALF_W{1'b0}}}
            + {{HALF_W{1'b0}}, pp.p10, {HALF_W{1'b0}}};
        return s;
    endfunction

    // low 64 bits of a product from the low-order partial products
    function automatic logic [WORD_W-1:0] pp_low(
        input logic [WORD_W-1:0] p00,
        input logic [HALF_W-1:0] p01_lo,
        input logic [HALF_W-1:0] p10_lo
    );
        logic [HALF_W-1:0] mid;
        mid = p01_lo + p10_lo;
        return p00 + {mid, {HALF_W{1'b0}}};
    endfunction

endpackage

`default_nettype wire

// ===== design/bred_front.sv =====
// front end: accepts value requests and forms the 64-bit quotient estimate
// depends on bred_pkg
`default_nettype none

module bred_front
    import bred_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [WORD_W-1:0]   value_low,
    input  wire logic [WORD_W-1:0]   value_high,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output q_entry_t                 push_data
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic              en;

    // stage 1: partial products
    pp_t               pa_reg, pb_reg, pc_reg, pd_reg;
    logic [WORD_W-1:0] x0_s1_reg;
    // stage 2: combined products
    logic [WORD_W-1:0] hi1_reg, lo2_reg, hi2_reg, lo3_reg, hi3_reg, dlo_reg;
    logic [WORD_W-1:0] x0_s2_reg;
    // stage 3: carry sum and partial estimate
    logic [1:0]        carry_reg;
    logic [WORD_W-1:0] psum_reg;
    logic [WORD_W-1:0] x0_s3_reg;
    // stage 4: estimate
    q_entry_t          out_reg;

    logic [HALF_W-1:0] x0l, x0h, x1l, x1h, rll, rlh, rhl, rhh;
    logic [2*WORD_W-1:0] prod_a, prod_b, prod_c;
    logic [WORD_W+1:0]   tsum;

    assign x0l = value_low[HALF_W-1:0];
    assign x0h = value_low[WORD_W-1:HALF_W];
    assign x1l = value_high[HALF_W-1:0];
    assign x1h = value_high[WORD_W-1:HALF_W];
    assign rll = cfg.ratio_low[HALF_W-1:0];
    assign rlh = cfg.ratio_low[WORD_W-1:HALF_W];
    assign rhl = cfg.ratio_high[HALF_W-1:0];
    assign rhh = cfg.ratio_high[WORD_W-1:HALF_W];

    assign en         = !v_reg[STAGES-1] || push_ready;
    assign in_ready   = en;
    assign push_valid = v_reg[STAGES-1];
    assign push_data  = out_reg;

    assign prod_a = pp_full(pa_reg);
    assign prod_b = pp_full(pb_reg);
    assign prod_c = pp_full(pc_reg);
    assign tsum   = {2'b00, lo2_reg} + {2'b00, hi1_reg} + {2'b00, lo3_reg};

    always_comb
    begin
        v_next = {v_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= '{p00: mul_half(x0l, rll), p01: mul_half(x0l, rlh),
                        p10: mul_half(x0h, rll), p11: mul_half(x0h, rlh)};
            pb_reg <= '{p00: mul_half(x0l, rhl), p01: mul_half(x0l, rhh),
                        p10: mul_half(x0h, rhl), p11: mul_half(x0h, rhh)};
            pc_reg <= '{p00: mul_half(x1l, rll), p01: mul_half(x1l, rlh),
                        p10: mul_half(x1h, rll), p11: mul_half(x1h, rlh)};
            // only the low word of value_high * ratio_high is needed
            pd_reg <= '{p00: mul_half(x1l, rhl), p01: mul_half(x1l, rhh),
                        p10: mul_half(x1h, rhl), p11: '0};
            x0_s1_reg <= value_low;

            hi1_reg   <= prod_a[2*WORD_W-1:WORD_W];
            lo2_reg   <= prod_b[WORD_W-1:0];
            hi2_reg   <= prod_b[2*WORD_W-1:WORD_W];
            lo3_reg   <= prod_c[WORD_W-1:0];
            hi3_reg   <= prod_c[2*WORD_W-1:WORD_W];
            dlo_reg   <= pp_low(pd_reg.p00, pd_reg.p01[HALF_W-1:0], pd_reg.p10[HALF_W-1:0]);
            x0_s2_reg <= x0_s1_reg;

            // both middle-word carries at once
            carry_reg <= tsum[WORD_W+1:WORD_W];
            psum_reg  <= dlo_reg + hi2_reg + hi3_reg;
            x0_s3_reg <= x0_s2_reg;

            out_reg.est <= psum_reg + {{(WORD_W-2){1'b0}}, carry_reg};
            out_reg.x0  <= x0_s3_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/bred_queue.sv =====
// short fifo between the estimate front end and the correction back end
// depends on bred_pkg
`default_nettype none

module bred_queue
    import bred_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire q_entry_t  push_data,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output q_entry_t       pop_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    q_entry_t          mem [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/bred_back.sv =====
// back end: subtracts estimate times modulus and applies the final correction
// depends on bred_pkg
`default_nettype none

module bred_back
    import bred_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [MOD_W-1:0]   modulus,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire q_entry_t           pop_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [MOD_W-1:0]        remainder
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] v_reg;
    logic              en;

    logic [WORD_W-1:0] p00_reg;
    logic [HALF_W-1:0] p01_reg, p10_reg;
    logic [WORD_W-1:0] x0_s1_reg, x0_s2_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W-1:0] res_reg;

    logic [HALF_W-1:0] e0, e1, m0, m1;
    logic [WORD_W-1:0] m_ext;
    logic [WORD_W-1:0] p01_full, p10_full;

    assign e0    = pop_data.est[HALF_W-1:0];
    assign e1    = pop_data.est[WORD_W-1:HALF_W];
    assign m_ext = {{(WORD_W-MOD_W){1'b0}}, modulus};
    assign m0    = m_ext[HALF_W-1:0];
    assign m1    = m_ext[WORD_W-1:HALF_W];
    assign p01_full = mul_half(e0, m1);
    assign p10_full = mul_half(e1, m0);

    assign en        = !v_reg[STAGES-1] || out_ready;
    assign pop_ready = en;
    assign out_valid = v_reg[STAGES-1];
    assign remainder = res_reg[MOD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-2:0], pop_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // low 64 bits of est * modulus only
            p00_reg   <= mul_half(e0, m0);
            p01_reg   <= p01_full[HALF_W-1:0];
            p10_reg   <= p10_full[HALF_W-1:0];
            x0_s1_reg <= pop_data.x0;

            prod_reg  <= pp_low(p00_reg, p01_reg, p10_reg);
            x0_s2_reg <= x0_s1_reg;

            r_reg     <= x0_s2_reg - prod_reg;

            // single conditional subtraction
            res_reg   <= (r_reg >= m_ext) ? r_reg - m_ext : r_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/barrett_reduce_128_mod64_core.sv =====
// top level of the barrett reduction core: configuration registers and the
// front end, queue and back end; depends on bred_pkg, bred_front, bred_queue, bred_back
`default_nettype none

// Reduces a 128-bit value (value_high:value_low) modulo a 63-bit modulus by
// Barrett's method and returns one remainder per request. Software loads the
// modulus (index 0) and floor(2^128 / modulus) as ratio_low (index 1) and
// ratio_high (index 2); write them only while no request is in flight, and a
// mismatched ratio gives a result that may not be the true remainder. The
// core takes one request every cycle while the output side keeps up: the
// front end forms the quotient estimate in four stages of registered 32x32
// partial products and adds, a short fifo decouples it, and the back end
// multiplies by the modulus, subtracts and corrects in four more stages.
// The fifo depth (QueueDepth, at least 2) sets how far the two halves can slip
// before in_ready drops.

module barrett_reduce_128_mod64_core
    import bred_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration writes
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [WORD_W-1:0]       cfg_data,
    // value requests
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [WORD_W-1:0]       value_low,
    input  wire logic [WORD_W-1:0]       value_high,
    // remainders
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [MOD_W-1:0]             remainder
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;

    logic     push_valid, push_ready;
    q_entry_t push_data;
    logic     pop_valid, pop_ready;
    q_entry_t pop_data;

    // registers are always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODULUS:    cfg_next.modulus    = cfg_data[MOD_W-1:0];
                CFG_RATIO_LOW:  cfg_next.ratio_low  = cfg_data;
                CFG_RATIO_HIGH: cfg_next.ratio_high = cfg_data;
                default:        cfg_next = cfg_reg;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus    <= MOD_W'(2);
            cfg_reg.ratio_low  <= '0;
            cfg_reg.ratio_high <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // quotient estimate
    bred_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_low  (value_low),
        .value_high (value_high),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling fifo
    bred_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // multiply back, subtract and correct
    bred_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .modulus   (cfg_reg.modulus),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .remainder (remainder)
    );

endmodule

`default_nettype wire

// ===== tb/barrett_reduce_128_mod64_core_tb.sv =====
// self-checking testbench for barrett_reduce_128_mod64_core: predicts each remainder
// from a local barrett model and compares it in order; needs bred_pkg and the core rtl

module barrett_reduce_128_mod64_core_tb;
    import bred_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // spare register index, writes to it must leave every register alone
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd3;

    // register values right after reset
    localparam logic [MOD_W-1:0]  MODULUS_RESET = 63'd2;
    localparam logic [WORD_W-1:0] RATIO_RESET   = 64'd0;

    // eight pipeline stages plus a short fifo, so this covers any stragglers
    localparam int DRAIN_CYCLES   = 24;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT    = 600000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [WORD_W-1:0]      value_low;
    logic [WORD_W-1:0]      value_high;
    logic                   out_valid;
    logic                   out_ready;
    logic [MOD_W-1:0]       remainder;

    // local copy of the configuration registers as the core should hold them
    logic [MOD_W-1:0]  modulus_mirror;
    logic [WORD_W-1:0] ratio_low_mirror;
    logic [WORD_W-1:0] ratio_high_mirror;

    // remainders still owed by the core, oldest first
    logic [MOD_W-1:0] expected_remainders[$];
    logic [MOD_W-1:0] owed_remainder;

    int mismatches;
    int requests_sent;
    int remainders_checked;
    int settings_loaded;
    int cycle_count;

    // idling controls shared by the sender, the receiver and the tests
    bit tx_idle_en;
    bit rx_idle_en;
    bit rx_hold_req;

    barrett_reduce_128_mod64_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_low  (value_low),
        .value_high (value_high),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .remainder  (remainder)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run guard: a hang anywhere ends the run as a failure
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d remainders still owed",
                 cycle_count, expected_remainders.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // barrett prediction
    // ------------------------------------------------------------------

    // quotient estimate from the value and the 128-bit ratio, low 64 bits only,
    // then one subtract of estimate times modulus and a single correction;
    // a wrong ratio or a modulus below two runs through the same steps
    function automatic logic [MOD_W-1:0] barrett_remainder(
        input logic [WORD_W-1:0] x0,
        input logic [WORD_W-1:0] x1
    );
        logic [2*WORD_W-1:0] prod;
        logic [WORD_W:0]     sum;
        logic [WORD_W-1:0]   carry_word;
        logic [WORD_W-1:0]   upper;
        logic [WORD_W-1:0]   acc;
        logic [WORD_W-1:0]   est;
        logic [WORD_W-1:0]   m;
        logic [WORD_W-1:0]   r;
        m = {1'b0, modulus_mirror};
        // only the carry word of x0 * ratio_low matters
        prod = {{WORD_W{1'b0}}, x0} * {{WORD_W{1'b0}}, ratio_low_mirror};
        carry_word = prod[2*WORD_W-1:WORD_W];
        // x0 * ratio_high with that word added in
        prod = {{WORD_W{1'b0}}, x0} * {{WORD_W{1'b0}}, ratio_high_mirror};
        sum = {1'b0, prod[WORD_W-1:0]} + {1'b0, carry_word};
        acc = sum[WORD_W-1:0];
        upper = prod[2*WORD_W-1:WORD_W] + {{(WORD_W-1){1'b0}}, sum[WORD_W]};
        // x1 * ratio_low into the middle word
        prod = {{WORD_W{1'b0}}, x1} * {{WORD_W{1'b0}}, ratio_low_mirror};
        sum = {1'b0, acc} + {1'b0, prod[WORD_W-1:0]};
        carry_word = prod[2*WORD_W-1:WORD_W] + {{(WORD_W-1){1'b0}}, sum[WORD_W]};
        // x1 * ratio_high only reaches the estimate through its low word
        est = x1 * ratio_high_mirror + upper + carry_word;
        r = x0 - est * m;
        if (r >= m)
            r = r - m;
        return r[MOD_W-1:0];
    endfunction

    // floor(2^128 / m), what software loads as the ratio for a modulus of two or more
    function automatic logic [2*WORD_W-1:0] ratio_for(input logic [MOD_W-1:0] m);
        logic [2*WORD_W:0] num;
        logic [2*WORD_W:0] quo;
        num = '0;
        num[2*WORD_W] = 1'b1;
        quo = num / {{(2*WORD_W+1-MOD_W){1'b0}}, m};
        return quo[2*WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly random widths, now and then the edges of the legal range
    function automatic logic [MOD_W-1:0] pick_modulus();
        logic [MOD_W-1:0] m;
        int width;
        case ($urandom_range(0, 9))
            0: m = 63'd2;
            1: m = {MOD_W{1'b1}};
            2: m = 63'd1 << 62;
            3: m = 63'd3;
            default:
            begin
                width = $urandom_range(2, MOD_W);
                m = MOD_W'(rand_word() & ((64'd1 << width) - 64'd1));
                m[width-1] = 1'b1;
            end
        endcase
        return m;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [MOD_W-1:0] got,
                                   input logic [MOD_W-1:0] want);
        $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // every remainder the core hands over is matched against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_remainders.size() == 0)
                report_mismatch("remainder with no request owed", remainder, '0);
            else
            begin
                owed_remainder = expected_remainders.pop_front();
                if (remainder !== owed_remainder)
                    report_mismatch("remainder", remainder, owed_remainder);
                remainders_checked++;
            end
        end
    end

    // receiver side: random stall bursts, one long hold-off on request, else ready
    initial
    begin : rx_side
        int n;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                for (n = 0; n < RX_HOLD_CYCLES; n++)
                    @(posedge clk);
                rx_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // one value request; valid is left high so a back-to-back request keeps it up,
    // the owed remainder is worked out with the settings in force at acceptance
    task automatic send_value(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        value_low  <= lo;
        value_high <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_remainders.push_back(barrett_remainder(lo, hi));
        requests_sent++;
    endtask

    // one register write; valid stays high so writes can follow back to back,
    // the caller lowers it when the batch is done
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_MODULUS:    modulus_mirror = data[MOD_W-1:0];
            CFG_RATIO_LOW:  ratio_low_mirror = data;
            CFG_RATIO_HIGH: ratio_high_mirror = data;
            default:        ;
        endcase
    endtask

    // registers may only change with nothing in flight: drop valid, wait for
    // every owed remainder, then let the pipeline run empty
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_remainders.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // modulus plus its matching ratio, as software would load them
    task automatic load_modulus(input logic [MOD_W-1:0] m);
        logic [2*WORD_W-1:0] ratio;
        ratio = ratio_for(m);
        settle();
        write_reg(CFG_MODULUS, {1'b0, m});
        write_reg(CFG_RATIO_LOW, ratio[WORD_W-1:0]);
        write_reg(CFG_RATIO_HIGH, ratio[2*WORD_W-1:WORD_W]);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // value mix: full random, one half pinned, sparse bits, and values right at
    // or next to a multiple of the modulus where the correction step decides
    task automatic send_random_values(input int count);
        logic [WORD_W-1:0]   lo;
        logic [WORD_W-1:0]   hi;
        logic [WORD_W-1:0]   k;
        logic [WORD_W-1:0]   off;
        logic [2*WORD_W-1:0] v;
        int i;
        for (i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    lo = rand_word();
                    hi = '0;
                end
                1:
                begin
                    lo = rand_word();
                    hi = '1;
                end
                2:
                begin
                    lo = 64'd1 << $urandom_range(0, 63);
                    hi = 64'd1 << $urandom_range(0, 63);
                end
                3, 4:
                begin
                    k = rand_word();
                    case ($urandom_range(0, 3))
                        0: off = '0;
                        1: off = {1'b0, modulus_mirror} - 64'd1;
                        2: off = {1'b0, modulus_mirror};
                        default: off = rand_word() & {1'b0, modulus_mirror};
                    endcase
                    v = {{WORD_W{1'b0}}, k} * {{(WORD_W+1){1'b0}}, modulus_mirror}
                        + {{WORD_W{1'b0}}, off};
                    lo = v[WORD_W-1:0];
                    hi = v[2*WORD_W-1:WORD_W];
                end
                default:
                begin
                    lo = rand_word();
                    hi = rand_word();
                end
            endcase
            send_value(lo, hi);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset leaves modulus two and a zero ratio: estimate is zero, so the
    // remainder is the low word after one correction
    task automatic test_reset_state();
        send_value(64'd5, 64'hDEAD_BEEF_0000_0001);
        send_value('1, '1);
        send_value('0, '0);
    endtask

    // field extremes at both ends of the modulus range
    task automatic test_value_extremes();
        logic [MOD_W-1:0] m;
        m = {MOD_W{1'b1}};
        load_modulus(m);
        send_value('0, '0);
        send_value('1, '1);
        send_value('1, '0);
        send_value('0, '1);
        send_value({1'b0, m}, '0);
        send_value({1'b0, m} - 64'd1, '0);
        send_value({m, 1'b0}, '0);
        load_modulus(63'd2);
        send_value('1, '1);
        send_value(64'd1, '0);
    endtask

    // modulus below two, masking of the top data bit, the spare index and a
    // ratio that does not match the modulus
    task automatic test_special_cases();
        // bit 63 of the data is dropped, leaving modulus one
        settle();
        write_reg(CFG_MODULUS, 64'h8000_0000_0000_0001);
        write_reg(CFG_RATIO_LOW, '1);
        write_reg(CFG_RATIO_HIGH, '1);
        cfg_valid <= 1'b0;
        send_value(rand_word(), rand_word());
        send_value('1, '1);
        // modulus zero: the correction subtracts nothing
        settle();
        write_reg(CFG_MODULUS, 64'h8000_0000_0000_0000);
        cfg_valid <= 1'b0;
        send_value(rand_word(), rand_word());
        send_value('1, '0);
        // spare index must not touch any register
        load_modulus(63'd1000003);
        send_value(rand_word(), rand_word());
        settle();
        write_reg(CFG_INDEX_SPARE, '1);
        cfg_valid <= 1'b0;
        send_value(rand_word(), rand_word());
        // ratio off by a lot
        settle();
        write_reg(CFG_RATIO_LOW, '1);
        write_reg(CFG_RATIO_HIGH, rand_word());
        cfg_valid <= 1'b0;
        send_value('1, '1);
        send_value(rand_word(), rand_word());
    endtask

    // proper settings, random moduli, idling on both sides
    task automatic test_random_moduli();
        int phase;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (phase = 0; phase < 6; phase++)
        begin
            load_modulus(pick_modulus());
            send_random_values(200);
        end
    endtask

    // garbage ratios and the small moduli, same datapath either way
    task automatic test_mismatched_ratio();
        int phase;
        for (phase = 0; phase < 3; phase++)
        begin
            settle();
            write_reg(CFG_MODULUS, rand_word());
            write_reg(CFG_RATIO_LOW, rand_word());
            write_reg(CFG_RATIO_HIGH, rand_word());
            cfg_valid <= 1'b0;
            send_random_values(40);
        end
        settle();
        write_reg(CFG_MODULUS, 64'd1);
        cfg_valid <= 1'b0;
        send_random_values(20);
        settle();
        write_reg(CFG_MODULUS, 64'd0);
        cfg_valid <= 1'b0;
        send_random_values(20);
    endtask

    // receiver holds off for a long stretch while requests keep coming, so the
    // pipeline and fifo fill and in_ready has to drop
    task automatic test_output_holdoff();
        load_modulus(pick_modulus());
        tx_idle_en = 1'b0;
        rx_hold_req = 1'b1;
        send_random_values(60);
    endtask

    // last stretch at full rate, no idling anywhere
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        load_modulus(pick_modulus());
        send_random_values(150);
        load_modulus({MOD_W{1'b1}});
        send_random_values(150);
    endtask

    initial
    begin
        mismatches         = 0;
        requests_sent      = 0;
        remainders_checked = 0;
        settings_loaded    = 0;
        tx_idle_en         = 1'b0;
        rx_idle_en         = 1'b0;
        rx_hold_req        = 1'b0;
        modulus_mirror     = MODULUS_RESET;
        ratio_low_mirror   = RATIO_RESET;
        ratio_high_mirror  = RATIO_RESET;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_MODULUS;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        value_low  <= '0;
        value_high <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_value_extremes();
        test_special_cases();
        test_random_moduli();
        test_mismatched_ratio();
        test_output_holdoff();
        test_full_rate();

        // drain, then give a stray extra remainder time to show up
        settle();

        $display("covered %0d value requests over %0d loaded moduli plus reset, zero, one,",
                 requests_sent, settings_loaded);
        $display("spare-index and mismatched-ratio settings; %0d remainders checked",
                 remainders_checked);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bred_pkg.sv
design/bred_front.sv
design/bred_queue.sv
design/bred_back.sv
design/barrett_reduce_128_mod64_core.sv
tb/barrett_reduce_128_mod64_core_tb.sv
